FILE: sv/urkf_pkg.sv
// Shared types and constants for the ultrasonic range Kalman filter.
// No dependencies; imported by every module of the block.
package urkf_pkg;

   localparam int WIDTH_W    = 16;   // pulse width, microseconds
   localparam int DIST_W     = 17;   // distance, unsigned Q9.8 cm
   localparam int NOISE_W    = 32;   // noise and variance, unsigned Q16.16
   localparam int GAIN_W     = 17;   // Kalman gain, unsigned Q1.16
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int MUL_A_W    = 17;
   localparam int MUL_B_W    = 32;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_NOISE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MAX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPT_GATE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTLIER_GATE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_TIMEOUT = 3'd5;

   // register reset values
   localparam logic [NOISE_W-1:0] RST_MEAS_NOISE   = 32'd32768;
   localparam logic [DIST_W-1:0]  RST_RANGE_MIN    = 17'd512;
   localparam logic [DIST_W-1:0]  RST_RANGE_MAX    = 17'd102400;
   localparam logic [DIST_W-1:0]  RST_ADAPT_GATE   = 17'd2560;
   localparam logic [DIST_W-1:0]  RST_OUTLIER_GATE = 17'd12800;
   localparam logic [WIDTH_W-1:0] RST_ECHO_TIMEOUT = 16'd25000;

   // filter state reset values
   localparam logic [DIST_W-1:0]  RST_ESTIMATE = 17'd5120;   // 20 cm
   localparam logic [NOISE_W-1:0] ONE_Q16      = 32'h0001_0000;
   localparam logic [GAIN_W-1:0]  GAIN_ONE     = 17'h1_0000;

   // multiplier constants: width*0.0343/2 = width*281/64, blend 0.7/0.3 in Q.8
   localparam logic [MUL_A_W-1:0] CONV_SCALE = 17'd281;
   localparam logic [MUL_A_W-1:0] BLEND_MEAS = 17'd179;
   localparam logic [MUL_A_W-1:0] BLEND_EST  = 17'd77;

   // gain divider: k = (p << 16) / (p + r)
   typedef struct packed {
      logic                 start;
      logic [NOISE_W-1:0]   numer;
      logic [NOISE_W:0]     denom;
   } urkf_div_req_type;

   typedef struct packed {
      logic                 done;
      logic [GAIN_W-1:0]    quotient;
   } urkf_div_rsp_type;

endpackage

FILE: sv/urkf_divider.sv
// Serial restoring divider for the Kalman gain, one quotient bit per cycle.
// Depends on urkf_pkg.
module urkf_divider
   import urkf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  urkf_div_req_type div_req,
   output urkf_div_rsp_type div_rsp
);

   localparam int STEPS = GAIN_W;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NOISE_W:0]   rem_ff;
   logic [NOISE_W:0]   den_ff;
   logic [GAIN_W-1:0]  bits_ff;
   logic [GAIN_W-1:0]  quot_ff;
   logic               zero_ff;

   logic [NOISE_W+1:0] trial;
   logic [NOISE_W+1:0] diff;
   logic               ge;
   logic [NOISE_W:0]   rem_in;

   // remainder stays below the divisor, so the top bit of diff is always dropped
   always_comb begin
      trial  = {rem_ff, bits_ff[GAIN_W-1]};
      ge     = (trial >= {1'b0, den_ff});
      diff   = trial - {1'b0, den_ff};
      rem_in = ge ? diff[NOISE_W:0] : trial[NOISE_W:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // done pulses for one cycle after the last quotient bit
         done_ff <= busy_ff && !div_req.start && (cnt_ff == CNT_W'(1));
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // numerator is p << 16; its upper part p >> 1 is always below p + r
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff  <= {2'b00, div_req.numer[NOISE_W-1:1]};
         bits_ff <= {div_req.numer[0], {(GAIN_W-1){1'b0}}};
         den_ff  <= div_req.denom;
         zero_ff <= (div_req.denom == '0);
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         bits_ff <= {bits_ff[GAIN_W-2:0], 1'b0};
         quot_ff <= {quot_ff[GAIN_W-2:0], ge};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = zero_ff ? '0 : quot_ff;

endmodule

FILE: sv/ultrasonic_range_kalman_filter_top.sv
// Ultrasonic range filter top level: sequencer, shared multiplier, state.
// Depends on urkf_pkg and urkf_divider.
//
// Each request transaction carries an echo flag and a pulse width in us.
// The width becomes a distance in Q9.8 cm (width*281 >> 6) and, when the
// echo is present, shorter than echo_timeout and within [range_min,
// range_max], runs one adaptive scalar Kalman step: q doubles (saturating)
// on an innovation above adapt_gate and otherwise returns to 1.0,
// p = p + q, k = p/(p+r), the estimate moves by k*innovation (or takes a
// 0.7/0.3 blend at or above outlier_gate), is clamped to the range, and
// p = (1-k)*p. Every request yields exactly one response transaction.
// One transaction is worked on at a time; req_ready is high only while
// the sequencer is idle. For an accepted measurement, the serial gain
// divider takes most of the time from acceptance to response valid; a
// rejected one goes from the range check straight to the output register.
// req_ready rises together with response valid, so a new request is
// accepted only once the previous response has been loaded for output.
// All multiplications go through one registered 17x32 multiplier. A
// finished response sits in the output register while the next request
// is accepted. Configuration writes (csr_we/csr_index/csr_wdata) are
// registered directly and must only happen while no transaction is in flight.
module ultrasonic_range_kalman_filter_top
   import urkf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_echo_received,
   input  logic [WIDTH_W-1:0]    req_pulse_width_us,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DIST_W-1:0]     rsp_filtered_distance,
   output logic [DIST_W-1:0]     rsp_raw_distance,
   output logic                  rsp_was_updated,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONV,
      ST_CHECK,
      ST_INNOV,
      ST_NOISE,
      ST_VAR,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_CORR_MUL,
      ST_CORR_ADD,
      ST_BLEND_MEAS,
      ST_BLEND_EST,
      ST_BLEND_SUM,
      ST_CLAMP,
      ST_VAR_UPD,
      ST_DONE
   } state_type;

   localparam int DSUM_W = DIST_W + 2;   // converted distance before saturation
   localparam int X_W    = DIST_W + 3;   // signed candidate estimate
   localparam int ACC_W  = 25;           // 179 * 131071 fits here

   // configuration registers
   logic [NOISE_W-1:0]  cfg_noise_ff;
   logic [DIST_W-1:0]   cfg_min_ff;
   logic [DIST_W-1:0]   cfg_max_ff;
   logic [DIST_W-1:0]   cfg_adapt_ff;
   logic [DIST_W-1:0]   cfg_outlier_ff;
   logic [WIDTH_W-1:0]  cfg_timeout_ff;

   // sequencer and filter state
   state_type           state_ff;
   logic [DIST_W-1:0]   est_ff;
   logic [NOISE_W-1:0]  p_ff;
   logic [NOISE_W-1:0]  q_ff;

   // per-transaction working registers
   logic                echo_ff;
   logic [WIDTH_W-1:0]  width_ff;
   logic [DSUM_W-1:0]   dist_ff;
   logic [DIST_W-1:0]   raw_ff;
   logic                neg_ff;
   logic [DIST_W-1:0]   mag_ff;
   logic [GAIN_W-1:0]   k_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic signed [X_W-1:0] x_ff;
   logic                updated_ff;

   // output register
   logic                rsp_valid_ff;
   logic [DIST_W-1:0]   rsp_filtered_ff;
   logic [DIST_W-1:0]   rsp_raw_ff;
   logic                rsp_updated_ff;

   // shared multiplier
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [PROD_W-1:0]   prod_in;
   logic [PROD_W-1:0]   prod_ff;

   urkf_div_req_type    div_req;
   urkf_div_rsp_type    div_rsp;

   // datapath helpers
   logic [DSUM_W-1:0]   dist_c;
   logic                accept_c;
   logic [DIST_W:0]     innov_diff;
   logic [DIST_W:0]     innov_abs;
   logic [NOISE_W:0]    q_dbl;
   logic [NOISE_W-1:0]  q_sat;
   logic [NOISE_W:0]    p_sum;
   logic [NOISE_W-1:0]  p_sat;
   logic [34:0]         corr_sum;
   logic signed [X_W-1:0] corr_ext;
   logic signed [X_W-1:0] est_ext;
   logic signed [X_W-1:0] x_corr;
   logic [ACC_W:0]      blend_sum;
   logic signed [X_W-1:0] min_ext;
   logic signed [X_W-1:0] max_ext;
   logic signed [X_W-1:0] x_lo;
   logic signed [X_W-1:0] x_hi;
   logic [DIST_W-1:0]   est_in;
   logic [PROD_W:0]     pnew_sum;
   logic [NOISE_W-1:0]  p_in;

   assign req_ready = (state_ff == ST_IDLE);

   // configuration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_noise_ff   <= RST_MEAS_NOISE;
         cfg_min_ff     <= RST_RANGE_MIN;
         cfg_max_ff     <= RST_RANGE_MAX;
         cfg_adapt_ff   <= RST_ADAPT_GATE;
         cfg_outlier_ff <= RST_OUTLIER_GATE;
         cfg_timeout_ff <= RST_ECHO_TIMEOUT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MEAS_NOISE:   cfg_noise_ff   <= csr_wdata[NOISE_W-1:0];
            CSR_RANGE_MIN:    cfg_min_ff     <= csr_wdata[DIST_W-1:0];
            CSR_RANGE_MAX:    cfg_max_ff     <= csr_wdata[DIST_W-1:0];
            CSR_ADAPT_GATE:   cfg_adapt_ff   <= csr_wdata[DIST_W-1:0];
            CSR_OUTLIER_GATE: cfg_outlier_ff <= csr_wdata[DIST_W-1:0];
            CSR_ECHO_TIMEOUT: cfg_timeout_ff <= csr_wdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   // operand select for the shared multiplier; product is ready next cycle
   always_comb begin
      case (state_ff)
         ST_CONV: begin
            mul_a = CONV_SCALE;
            mul_b = MUL_B_W'(width_ff);
         end
         ST_CORR_MUL: begin
            mul_a = k_ff;
            mul_b = MUL_B_W'(mag_ff);
         end
         ST_BLEND_MEAS: begin
            mul_a = BLEND_MEAS;
            mul_b = MUL_B_W'(dist_ff[DIST_W-1:0]);
         end
         ST_BLEND_EST: begin
            mul_a = BLEND_EST;
            mul_b = MUL_B_W'(est_ff);
         end
         ST_CLAMP: begin
            mul_a = GAIN_ONE - k_ff;
            mul_b = p_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_comb begin
      // conversion: width*281 is under 2^25, so bits 24:6 hold the distance
      dist_c   = prod_ff[DSUM_W+5:6];
      accept_c = echo_ff && (width_ff < cfg_timeout_ff) &&
                 (dist_c >= DSUM_W'(cfg_min_ff)) && (dist_c <= DSUM_W'(cfg_max_ff));

      // innovation sign and magnitude
      innov_diff = {1'b0, dist_ff[DIST_W-1:0]} - {1'b0, est_ff};
      innov_abs  = innov_diff[DIST_W] ? (~innov_diff + 1'b1) : innov_diff;

      // adaptive process noise and predicted variance, both saturating
      q_dbl = {1'b0, q_ff} + {1'b0, q_ff};
      q_sat = q_dbl[NOISE_W] ? '1 : q_dbl[NOISE_W-1:0];
      p_sum = {1'b0, p_ff} + {1'b0, q_ff};
      p_sat = p_sum[NOISE_W] ? '1 : p_sum[NOISE_W-1:0];

      // gain correction rounded half away from zero (applied to magnitude)
      corr_sum = {1'b0, prod_ff[33:0]} + 35'd32768;
      corr_ext = signed'({1'b0, corr_sum[34:16]});
      est_ext  = signed'(X_W'(est_ff));
      x_corr   = neg_ff ? (est_ext - corr_ext) : (est_ext + corr_ext);

      // outlier blend: 179*meas + 77*est + 128, then >> 8
      blend_sum = {1'b0, acc_ff} + {1'b0, prod_ff[ACC_W-1:0]} + (ACC_W+1)'(128);

      // clamp: raise to range_min first, then lower to range_max
      min_ext = signed'(X_W'(cfg_min_ff));
      max_ext = signed'(X_W'(cfg_max_ff));
      x_lo    = (x_ff < min_ext) ? min_ext : x_ff;
      x_hi    = (x_lo > max_ext) ? max_ext : x_lo;
      est_in  = x_hi[X_W-1] ? '0 : x_hi[DIST_W-1:0];

      // posterior variance ((1-k)*p + 0.5) >> 16
      pnew_sum = {1'b0, prod_ff} + (PROD_W+1)'(32768);
      p_in     = (pnew_sum[PROD_W:16] > (PROD_W-15)'(32'hFFFF_FFFF)) ?
                 '1 : pnew_sum[NOISE_W+15:16];
   end

   assign div_req.start = (state_ff == ST_DIV_START);
   assign div_req.numer = p_ff;
   assign div_req.denom = {1'b0, p_ff} + {1'b0, cfg_noise_ff};

   urkf_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         est_ff       <= RST_ESTIMATE;
         p_ff         <= ONE_Q16;
         q_ff         <= ONE_Q16;
         rsp_valid_ff <= 1'b0;
         updated_ff   <= 1'b0;
      end else begin
         // ST_DONE reloads the output register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  echo_ff  <= req_echo_received;
                  width_ff <= req_pulse_width_us;
                  state_ff <= ST_CONV;
               end
            end
            ST_CONV: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               dist_ff    <= dist_c;
               raw_ff     <= (|dist_c[DSUM_W-1:DIST_W]) ? '1 : dist_c[DIST_W-1:0];
               updated_ff <= accept_c;
               state_ff   <= accept_c ? ST_INNOV : ST_DONE;
            end
            ST_INNOV: begin
               neg_ff   <= innov_diff[DIST_W];
               mag_ff   <= innov_abs[DIST_W-1:0];
               state_ff <= ST_NOISE;
            end
            ST_NOISE: begin
               q_ff     <= (mag_ff > cfg_adapt_ff) ? q_sat : ONE_Q16;
               state_ff <= ST_VAR;
            end
            ST_VAR: begin
               p_ff     <= p_sat;
               state_ff <= ST_DIV_START;
            end
            ST_DIV_START: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_rsp.done) begin
                  k_ff     <= div_rsp.quotient;
                  state_ff <= (mag_ff < cfg_outlier_ff) ? ST_CORR_MUL : ST_BLEND_MEAS;
               end
            end
            ST_CORR_MUL: begin
               state_ff <= ST_CORR_ADD;
            end
            ST_CORR_ADD: begin
               x_ff     <= x_corr;
               state_ff <= ST_CLAMP;
            end
            ST_BLEND_MEAS: begin
               state_ff <= ST_BLEND_EST;
            end
            ST_BLEND_EST: begin
               acc_ff   <= prod_ff[ACC_W-1:0];
               state_ff <= ST_BLEND_SUM;
            end
            ST_BLEND_SUM: begin
               x_ff     <= signed'(X_W'(blend_sum[ACC_W:8]));
               state_ff <= ST_CLAMP;
            end
            ST_CLAMP: begin
               est_ff   <= est_in;
               state_ff <= ST_VAR_UPD;
            end
            ST_VAR_UPD: begin
               p_ff     <= p_in;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               // hold here until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_filtered_ff <= est_ff;
                  rsp_raw_ff      <= raw_ff;
                  rsp_updated_ff  <= updated_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_filtered_distance = rsp_filtered_ff;
   assign rsp_raw_distance      = rsp_raw_ff;
   assign rsp_was_updated       = rsp_updated_ff;

endmodule

FILE: sv/urkf_checker.sv
// Port-level checks for the ultrasonic range filter, bound to the top level.
// Depends on urkf_pkg and ultrasonic_range_kalman_filter_top.
module urkf_checker
   import urkf_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [DIST_W-1:0]    rsp_filtered_distance,
   input logic [DIST_W-1:0]    rsp_raw_distance,
   input logic                 rsp_was_updated
);

   // one transaction in flight at a time
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a transaction was in flight");

   // a response never shows up the cycle right after its request
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response appeared too early after request");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered_distance) &&
      $stable(rsp_raw_distance) && $stable(rsp_was_updated))
      else $error("stalled response changed");

endmodule

bind ultrasonic_range_kalman_filter_top urkf_checker u_urkf_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_filtered_distance (rsp_filtered_distance),
   .rsp_raw_distance      (rsp_raw_distance),
   .rsp_was_updated       (rsp_was_updated)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for ultrasonic_range_kalman_filter_top.
// Depends on urkf_pkg and the filter RTL; a built-in predictor supplies the expected results.
module tb_top;
   import urkf_pkg::*;

   // Cycles with neither channel moving before the run is declared hung.
   // The worst case is a long random receiver stall plus one filter step.
   localparam int WATCHDOG_LIMIT = 5000;
   // Quiet time after the last response, so a stray extra one still gets caught.
   localparam int TAIL_CYCLES    = 64;
   localparam int RAND_PHASES    = 8;
   localparam int PHASE_ITEMS    = 75;

   // Expected response transaction, one per request.
   typedef struct packed {
      logic [DIST_W-1:0] filtered;
      logic [DIST_W-1:0] raw;
      logic              updated;
   } range_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_echo_received = 1'b0;
   logic [WIDTH_W-1:0]    req_pulse_width_us = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DIST_W-1:0]     rsp_filtered_distance;
   logic [DIST_W-1:0]     rsp_raw_distance;
   logic                  rsp_was_updated;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Register shadows, written in step with the CSR port.
   logic [NOISE_W-1:0]    cfg_meas_noise;
   logic [DIST_W-1:0]     cfg_range_min;
   logic [DIST_W-1:0]     cfg_range_max;
   logic [DIST_W-1:0]     cfg_adapt_gate;
   logic [DIST_W-1:0]     cfg_outlier_gate;
   logic [WIDTH_W-1:0]    cfg_echo_timeout;

   // Filter state as the predictor sees it.
   logic [DIST_W-1:0]     kf_estimate;
   logic [NOISE_W-1:0]    kf_variance;
   logic [NOISE_W-1:0]    kf_qnoise;

   range_rsp_type         pending_rsp[$];
   range_rsp_type         rsp_want;
   int                    err_count = 0;
   int                    quiet_cycles = 0;
   int                    send_idle_pct = 0;
   int                    rsp_stall_pct = 0;

   ultrasonic_range_kalman_filter_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_echo_received     (req_echo_received),
      .req_pulse_width_us    (req_pulse_width_us),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_filtered_distance (rsp_filtered_distance),
      .rsp_raw_distance      (rsp_raw_distance),
      .rsp_was_updated       (rsp_was_updated),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver back-pressure; stall rate set per phase.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic logic [NOISE_W-1:0] sat_q16(input longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? '1 : v[NOISE_W-1:0];
   endfunction

   function automatic void model_reset();
      cfg_meas_noise   = RST_MEAS_NOISE;
      cfg_range_min    = RST_RANGE_MIN;
      cfg_range_max    = RST_RANGE_MAX;
      cfg_adapt_gate   = RST_ADAPT_GATE;
      cfg_outlier_gate = RST_OUTLIER_GATE;
      cfg_echo_timeout = RST_ECHO_TIMEOUT;
      kf_estimate      = RST_ESTIMATE;
      kf_variance      = ONE_Q16;
      kf_qnoise        = ONE_Q16;
   endfunction

   // One measurement: convert the width, gate it, and run the adaptive Kalman step.
   function automatic range_rsp_type kalman_step(input logic echo,
                                                 input logic [WIDTH_W-1:0] width);
      longint unsigned dist_q8, mag, pv, denom, gain, corr, blend, pnext;
      longint unsigned mv, ev;
      longint          meas_s, est_s, innov, x, lo, hi;
      range_rsp_type   r;
      dist_q8 = 64'(width);
      dist_q8 = (dist_q8 * 281) >> 6;
      r.raw = (dist_q8 > 64'h1FFFF) ? '1 : dist_q8[DIST_W-1:0];
      r.updated = 1'b0;
      // Range check uses the unsaturated distance.
      if (echo && width < cfg_echo_timeout && dist_q8 >= cfg_range_min &&
          dist_q8 <= cfg_range_max) begin
         meas_s = r.raw;
         est_s  = kf_estimate;
         innov  = meas_s - est_s;
         mag    = (innov < 0) ? -innov : innov;
         // Adaptive q: double on a big jump, otherwise back to 1.0.
         pv = kf_qnoise;
         if (mag > cfg_adapt_gate) kf_qnoise = sat_q16(pv + pv);
         else kf_qnoise = ONE_Q16;
         pv = kf_variance;
         pv = pv + kf_qnoise;
         kf_variance = sat_q16(pv);
         pv = kf_variance;
         denom = pv + cfg_meas_noise;
         gain = (denom != 0) ? ((pv << 16) / denom) : 0;
         if (mag < cfg_outlier_gate) begin
            corr = (gain * mag + 32768) >> 16;
            x = (innov < 0) ? (est_s - corr) : (est_s + corr);
         end else begin
            // Outlier: fixed 0.7/0.3 blend toward the measurement.
            mv = r.raw;
            ev = kf_estimate;
            blend = (179 * mv + 77 * ev + 128) >> 8;
            x = blend;
         end
         lo = cfg_range_min;
         hi = cfg_range_max;
         if (x < lo) x = lo;
         if (x > hi) x = hi;
         if (x < 0) x = 0;
         kf_estimate = x[DIST_W-1:0];
         pnext = ((65536 - gain) * pv + 32768) >> 16;
         kf_variance = sat_q16(pnext);
         r.updated = 1'b1;
      end
      r.filtered = kf_estimate;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus primitives
   // ---------------------------------------------------------------------
   // Send one request transaction; the prediction is queued when it is accepted.
   task automatic send_meas(input logic echo, input logic [WIDTH_W-1:0] width);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_echo_received  <= echo;
      req_pulse_width_us <= width;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(kalman_step(echo, width));
      @(negedge clock);
   endtask

   // Stop sending and wait until every response has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // Register write, only with the filter idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MEAS_NOISE:   cfg_meas_noise   = data;
         CSR_RANGE_MIN:    cfg_range_min    = data[DIST_W-1:0];
         CSR_RANGE_MAX:    cfg_range_max    = data[DIST_W-1:0];
         CSR_ADAPT_GATE:   cfg_adapt_gate   = data[DIST_W-1:0];
         CSR_OUTLIER_GATE: cfg_outlier_gate = data[DIST_W-1:0];
         CSR_ECHO_TIMEOUT: cfg_echo_timeout = data[WIDTH_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Response checker and hang watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected response transaction: filtered_distance %0d",
                      rsp_filtered_distance);
               err_count++;
            end else begin
               rsp_want = pending_rsp.pop_front();
               if (rsp_filtered_distance !== rsp_want.filtered) begin
                  $error("filtered_distance mismatch: expected %0d, actual %0d",
                         rsp_want.filtered, rsp_filtered_distance);
                  err_count++;
               end
               if (rsp_raw_distance !== rsp_want.raw) begin
                  $error("raw_distance mismatch: expected %0d, actual %0d",
                         rsp_want.raw, rsp_raw_distance);
                  err_count++;
               end
               if (rsp_was_updated !== rsp_want.updated) begin
                  $error("was_updated mismatch: expected %0d, actual %0d",
                         rsp_want.updated, rsp_was_updated);
                  err_count++;
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Reset register values: every rejection reason, range edges, both update paths.
   task automatic test_default_config();
      send_meas(1'b0, 16'd1166);    // echo missing, width otherwise valid
      send_meas(1'b1, 16'd0);       // zero distance, below range_min
      send_meas(1'b1, 16'hFFFF);    // raw saturates, also past timeout
      send_meas(1'b1, 16'd25000);   // exactly at timeout
      send_meas(1'b1, 16'd24999);   // under timeout but above range_max
      send_meas(1'b1, 16'd117);     // 513, just inside min; big jump doubles q
      send_meas(1'b1, 16'd116);     // 509, just below min
      send_meas(1'b1, 16'd23319);   // 102384, near max; outlier blend
      send_meas(1'b1, 16'd23324);   // 102406, just above max
      send_meas(1'b1, 16'd1166);    // large jump back down
   endtask

   // Register extremes, clamping and the inverted range.
   task automatic test_register_corners();
      write_reg(CSR_MEAS_NOISE, 32'd1);
      write_reg(CSR_RANGE_MIN, 32'd0);
      write_reg(CSR_RANGE_MAX, 32'd131071);
      write_reg(CSR_ECHO_TIMEOUT, 32'd65535);
      send_meas(1'b1, 16'd29852);   // 131068, top of full range
      send_meas(1'b1, 16'd29853);   // unsaturated 131073 rejected
      send_meas(1'b1, 16'd0);       // zero distance accepted
      send_meas(1'b1, 16'hFFFF);    // at the largest timeout
      // shortest timeout: only width zero passes
      write_reg(CSR_ECHO_TIMEOUT, 32'd1);
      send_meas(1'b1, 16'd0);
      send_meas(1'b1, 16'd1);
      // huge r gives a tiny gain; gate zero doubles q on every move
      write_reg(CSR_ECHO_TIMEOUT, 32'd65535);
      write_reg(CSR_ADAPT_GATE, 32'd0);
      write_reg(CSR_OUTLIER_GATE, 32'd131071);
      write_reg(CSR_MEAS_NOISE, 32'hFFFF_FFFF);
      send_meas(1'b1, 16'd20000);
      send_meas(1'b1, 16'd1000);
      // widest gate never doubles; outlier gate zero forces the blend
      write_reg(CSR_ADAPT_GATE, 32'd131071);
      write_reg(CSR_OUTLIER_GATE, 32'd0);
      send_meas(1'b1, 16'd29852);
      send_meas(1'b1, 16'd29852);
      // estimate sits far above the new window: clamp to range_max
      write_reg(CSR_RANGE_MIN, 32'd40000);
      write_reg(CSR_RANGE_MAX, 32'd50000);
      send_meas(1'b1, 16'd10250);   // 45003
      // blend lands under the new window: raise to range_min
      write_reg(CSR_RANGE_MIN, 32'd60000);
      write_reg(CSR_RANGE_MAX, 32'd70000);
      send_meas(1'b1, 16'd13666);   // 60002
      // min above max: nothing accepted
      write_reg(CSR_RANGE_MIN, 32'd1000);
      write_reg(CSR_RANGE_MAX, 32'd999);
      send_meas(1'b1, 16'd228);
   endtask

   // Random registers per phase; mostly in-range echoes, some noise.
   task automatic test_random_traffic();
      int                 pick;
      longint unsigned    goal, offset, w;
      logic [NOISE_W-1:0] noise;
      logic [DIST_W-1:0]  lo, hi;
      logic               echo;
      logic [WIDTH_W-1:0] width;
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 83; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 83; end
            default: begin send_idle_pct = 36; rsp_stall_pct = 36; end
         endcase
         case ($urandom_range(3))
            0: noise = 32'd1;
            1: noise = 32'hFFFF_FFFF;
            2: noise = $urandom_range(32'h0004_0000, 1);
            default: begin
               noise = $urandom;
               if (noise == 0) noise = 32'd1;
            end
         endcase
         write_reg(CSR_MEAS_NOISE, noise);
         case ($urandom_range(3))
            0: begin lo = 17'd0; hi = 17'h1FFFF; end
            1: begin
               lo = DIST_W'($urandom_range(20000, 0));
               hi = DIST_W'(32'(lo) + $urandom_range(60000, 1000));
            end
            2: begin
               lo = DIST_W'($urandom_range(131071, 0));
               hi = DIST_W'($urandom_range(131071, lo));
            end
            default: begin   // may come out inverted
               lo = DIST_W'($urandom_range(131071, 0));
               hi = DIST_W'($urandom_range(131071, 0));
            end
         endcase
         write_reg(CSR_RANGE_MIN, CSR_DATA_W'(lo));
         write_reg(CSR_RANGE_MAX, CSR_DATA_W'(hi));
         case ($urandom_range(3))
            0: write_reg(CSR_ADAPT_GATE, 32'd0);
            1: write_reg(CSR_ADAPT_GATE, 32'd131071);
            2: write_reg(CSR_ADAPT_GATE, $urandom_range(8000, 0));
            default: write_reg(CSR_ADAPT_GATE, $urandom_range(131071, 0));
         endcase
         case ($urandom_range(3))
            0: write_reg(CSR_OUTLIER_GATE, 32'd0);
            1: write_reg(CSR_OUTLIER_GATE, 32'd131071);
            2: write_reg(CSR_OUTLIER_GATE, $urandom_range(30000, 2000));
            default: write_reg(CSR_OUTLIER_GATE, $urandom_range(131071, 0));
         endcase
         case ($urandom_range(3))
            0: write_reg(CSR_ECHO_TIMEOUT, 32'd65535);
            1: write_reg(CSR_ECHO_TIMEOUT, $urandom_range(65535, 1));
            default: write_reg(CSR_ECHO_TIMEOUT, $urandom_range(65535, 20000));
         endcase

         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               // well-formed echo aimed near the estimate or inside the window
               if ($urandom_range(1)) begin
                  goal   = kf_estimate;
                  offset = $urandom_range(4000, 0);
                  if ($urandom_range(1) && goal >= offset) goal = goal - offset;
                  else goal = goal + offset;
               end else if (cfg_range_min <= cfg_range_max) begin
                  goal = $urandom_range(cfg_range_max, cfg_range_min);
               end else begin
                  goal = $urandom_range(131071, 0);
               end
               w = (goal * 64 + 280) / 281;
               if (w > 65535) w = 65535;
               echo  = 1'b1;
               width = w[WIDTH_W-1:0];
            end else if (pick < 85) begin
               echo  = 1'b1;
               width = WIDTH_W'($urandom);
            end else begin
               echo  = 1'b0;
               width = WIDTH_W'($urandom);
            end
            send_meas(echo, width);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      model_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_config();
      test_register_corners();
      test_random_traffic();

      // drain, then keep watching for stray responses
      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/urkf_pkg.sv
sv/urkf_divider.sv
sv/ultrasonic_range_kalman_filter_top.sv
sv/urkf_checker.sv
verif/tb_top.sv
